/* rtl/lcar_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcar_pkg: shared types and constants of the load-cell converter reader
// Stream layouts, register indexes, action codes and the sequencer states.
// ----------------------------------------------------------------------------
package lcar_pkg;

  // stream widths, padded to whole bytes
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 56;

  // field widths
  localparam int ACTION_W  = 2;
  localparam int COEF_W    = 24;
  localparam int TARE_N_W  = 8;
  localparam int RAW_W     = 24;
  localparam int WEIGHT_W  = 25;
  localparam int SUM_W     = 32;
  localparam int CFG_IDX_W = 1;

  // input transaction layout
  localparam int IN_ACTION_LSB = 0;
  localparam int IN_DATA_BIT   = 2;

  // result transaction layout
  localparam int OUT_CLK_BIT    = 0;
  localparam int OUT_DONE_BIT   = 1;
  localparam int OUT_TARE_BIT   = 2;
  localparam int OUT_RAW_LSB    = 3;
  localparam int OUT_WEIGHT_LSB = 27;
  localparam int OUT_BUSY_BIT   = 52;

  localparam logic [COEF_W-1:0]   COEF_RESET   = 24'd27978;
  localparam logic [TARE_N_W-1:0] TARE_N_RESET = 8'd5;
  localparam logic [RAW_W-1:0]    WEIGHT_MAX   = 24'hFFFFFF;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_COEF   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TARE_READING = 1'b1;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_WEIGH = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_TARE  = 2'd2;

  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_WAIT  = 6'b000010,
    PH_HIGH  = 6'b000100,
    PH_LOW   = 6'b001000,
    PH_XHIGH = 6'b010000,
    PH_XLOW  = 6'b100000
  } phase_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* rtl/lcar_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcar_div: bit-serial restoring divider
// One quotient bit per cycle, most significant first.
// ----------------------------------------------------------------------------
module lcar_div #(
  parameter int DW = 32,
  parameter int VW = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [DW-1:0]      dividend,
  input  logic [VW-1:0]      divisor,
  output lcar_pkg::div_stat_t stat,
  output logic [DW-1:0]      quotient
);
  import lcar_pkg::*;

  localparam int CNT_W = $clog2(DW);

  logic [VW-1:0]    rem_r, rem_nxt;
  logic [DW-1:0]    quo_r, quo_nxt;
  logic [VW-1:0]    div_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [VW:0]      trial;
  logic [VW:0]      diff;
  logic             ge;

  // shift the next dividend bit into the partial remainder and try a subtract
  always_comb begin
    trial   = {rem_r, quo_r[DW-1]};
    diff    = trial - {1'b0, div_r};
    ge      = (trial >= {1'b0, div_r});
    rem_nxt = ge ? diff[VW-1:0] : trial[VW-1:0];
    quo_nxt = {quo_r[DW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DW - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      div_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

/* rtl/load_cell_adc_reader_with_tare.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// load_cell_adc_reader_with_tare: two-wire load-cell converter reader
// Clocks a conversion in bit by bit, keeps a tare offset and scales weights.
// ----------------------------------------------------------------------------
// a tick's result is registered at the edge that accepts it, unless it starts a divide
// a finishing tare, or a weighing off the tare offset, runs the bit-serial divider of
//   width DIV_W = max(SAMPLE_BITS+8, 32); its result is registered on divider done
// throughput: one tick per cycle while no divide runs or ends; a waiting result does
// not block the next tick while it is taken the same cycle
// reset (rst_n low, synchronous) returns to idle with zero offset and default registers
module load_cell_adc_reader_with_tare #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // config write port
  input  logic                               cfg_we,
  input  logic [lcar_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lcar_pkg::COEF_W-1:0]        cfg_wdata,
  // ticks in
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [lcar_pkg::IN_TDATA_W-1:0]    in_tdata,   // action[1:0], data_line[2]
  // results out
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // clock_line[0], done_res[1], done_was_tare[2], raw_reading[26:3],
  // weight[51:27], busy_res[52]
  output logic [lcar_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import lcar_pkg::*;

  localparam int SB    = SAMPLE_BITS;
  localparam int CNT_W = $clog2(SB + 1);
  localparam int DIV_W = (SB + 8 > SUM_W) ? SB + 8 : SUM_W;
  localparam logic [SB-1:0] TOP_BIT = {1'b1, {(SB-1){1'b0}}};

  logic [COEF_W-1:0]   coef_r;
  logic [TARE_N_W-1:0] tare_n_r;

  phase_t              phase_r, phase_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt, cnt_inc;
  logic [SB-1:0]       shift_r, shift_nxt;
  logic                tare_mode_r, tare_mode_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [TARE_N_W-1:0] tcnt_r, tcnt_nxt;
  logic [SB-1:0]       offset_r, offset_nxt;
  logic [SB-1:0]       last_raw_r, last_raw_nxt;
  logic                neg_r, neg_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic [ACTION_W-1:0] action;
  logic                data_line;
  logic                in_acc;
  logic [SB-1:0]       raw_w;
  logic                raw_neg;
  logic [SB-1:0]       mag;
  logic [TARE_N_W-1:0] n_eff;

  logic                res_load, res_clk, res_done;
  logic                div_start;
  logic [DIV_W-1:0]    div_dividend;
  logic [COEF_W-1:0]   div_divisor;
  div_stat_t           div_stat;
  logic [DIV_W-1:0]    div_q;
  logic [RAW_W-1:0]    w_mag;
  logic [WEIGHT_W-1:0] w_signed;

  assign action    = in_tdata[IN_ACTION_LSB +: ACTION_W];
  assign data_line = in_tdata[IN_DATA_BIT];
  assign in_tready = !div_stat.busy && !div_stat.done && (!out_valid_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;

  assign raw_w   = shift_r ^ TOP_BIT;
  assign raw_neg = (raw_w < offset_r);
  assign mag     = raw_neg ? (offset_r - raw_w) : (raw_w - offset_r);
  assign n_eff   = (tare_n_r == '0) ? TARE_N_W'(1) : tare_n_r;
  assign cnt_inc = cnt_r + 1'b1;

  // quotient saturation and sign for a weighing
  assign w_mag    = (|div_q[DIV_W-1:RAW_W]) ? WEIGHT_MAX : div_q[RAW_W-1:0];
  assign w_signed = neg_r ? (WEIGHT_W'(0) - {1'b0, w_mag}) : {1'b0, w_mag};

  lcar_div #(
    .DW(DIV_W),
    .VW(COEF_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .stat     (div_stat),
    .quotient (div_q)
  );

  always_comb begin
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    shift_nxt     = shift_r;
    tare_mode_nxt = tare_mode_r;
    sum_nxt       = sum_r;
    tcnt_nxt      = tcnt_r;
    offset_nxt    = offset_r;
    last_raw_nxt  = last_raw_r;
    neg_nxt       = neg_r;
    res_load      = 1'b0;
    res_clk       = 1'b0;
    res_done      = 1'b0;
    div_start     = 1'b0;
    div_dividend  = DIV_W'({mag, 8'h00});
    div_divisor   = coef_r;

    if (in_acc) begin
      res_load = 1'b1;
      case (phase_r)
        PH_IDLE: begin
          if (action == ACT_WEIGH || action == ACT_TARE) begin
            tare_mode_nxt = (action == ACT_TARE);
            sum_nxt       = '0;
            tcnt_nxt      = '0;
            cnt_nxt       = '0;
            shift_nxt     = '0;
            phase_nxt     = PH_WAIT;
          end
        end
        PH_WAIT: begin
          if (!data_line) begin
            cnt_nxt   = '0;
            shift_nxt = '0;
            phase_nxt = PH_HIGH;
          end
        end
        PH_HIGH: begin
          res_clk   = 1'b1;
          phase_nxt = PH_LOW;
        end
        PH_LOW: begin
          shift_nxt = {shift_r[SB-2:0], data_line};
          cnt_nxt   = cnt_inc;
          phase_nxt = (cnt_inc == CNT_W'(SB)) ? PH_XHIGH : PH_HIGH;
        end
        PH_XHIGH: begin
          res_clk   = 1'b1;
          phase_nxt = PH_XLOW;
        end
        PH_XLOW: begin
          last_raw_nxt = raw_w;
          if (tare_mode_r) begin
            sum_nxt  = sum_r + SUM_W'(raw_w);
            tcnt_nxt = tcnt_r + 1'b1;
            if (tcnt_nxt >= n_eff) begin
              // mean of the tare sum goes through the divider
              div_start    = 1'b1;
              res_load     = 1'b0;
              div_dividend = DIV_W'(sum_nxt);
              div_divisor  = COEF_W'(n_eff);
            end else begin
              phase_nxt = PH_WAIT;
            end
          end else if (mag == '0) begin
            res_done  = 1'b1;
            phase_nxt = PH_IDLE;
          end else begin
            div_start = 1'b1;
            res_load  = 1'b0;
            neg_nxt   = raw_neg;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end

    if (div_stat.done) begin
      phase_nxt = PH_IDLE;
      if (tare_mode_r) begin
        offset_nxt = div_q[SB-1:0];
      end
    end
  end

  // output register: loaded by an immediate tick result or by a finished divide
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_acc && res_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '0;
      out_data_nxt[OUT_CLK_BIT]  = res_clk;
      out_data_nxt[OUT_DONE_BIT] = res_done;
      out_data_nxt[OUT_RAW_LSB +: RAW_W] = RAW_W'(last_raw_nxt);
      out_data_nxt[OUT_BUSY_BIT] = (phase_nxt != PH_IDLE);
    end else if (div_stat.done) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '0;
      out_data_nxt[OUT_DONE_BIT] = 1'b1;
      out_data_nxt[OUT_TARE_BIT] = tare_mode_r;
      out_data_nxt[OUT_RAW_LSB +: RAW_W] = RAW_W'(last_raw_r);
      out_data_nxt[OUT_WEIGHT_LSB +: WEIGHT_W] = tare_mode_r ? '0 : w_signed;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r   <= COEF_RESET;
      tare_n_r <= TARE_N_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCALE_COEF:   coef_r   <= cfg_wdata;
        REG_TARE_READING: tare_n_r <= cfg_wdata[TARE_N_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      cnt_r       <= '0;
      shift_r     <= '0;
      tare_mode_r <= 1'b0;
      sum_r       <= '0;
      tcnt_r      <= '0;
      offset_r    <= '0;
      last_raw_r  <= '0;
      neg_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      shift_r     <= shift_nxt;
      tare_mode_r <= tare_mode_nxt;
      sum_r       <= sum_nxt;
      tcnt_r      <= tcnt_nxt;
      offset_r    <= offset_nxt;
      last_raw_r  <= last_raw_nxt;
      neg_r       <= neg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

/* rtl/lcar_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcar_checker: port-level checks of the load-cell converter reader
// Watches the result stream for consistency of its status bits over time.
// ----------------------------------------------------------------------------
module lcar_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [lcar_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import lcar_pkg::*;

  // no result transaction straight out of reset
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // a stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // a finishing transaction leaves the block idle
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[OUT_DONE_BIT] |-> !out_tdata[OUT_BUSY_BIT])
    else $error("busy on a finishing result");

  // a clock pulse only mid-conversion, never on a finishing tick
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[OUT_CLK_BIT] |-> out_tdata[OUT_BUSY_BIT] && !out_tdata[OUT_DONE_BIT])
    else $error("clock pulse outside a conversion");

  // the tare flag only comes with done
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[OUT_TARE_BIT] |-> out_tdata[OUT_DONE_BIT])
    else $error("tare flag without done");

endmodule

bind load_cell_adc_reader_with_tare lcar_checker u_lcar_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

/* sim/load_cell_adc_reader_with_tare_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// load_cell_adc_reader_with_tare_test: testbench of the load-cell reader
// Feeds serial clock ticks with a modeled converter data line, predicts every
// result transaction with an in-bench model of the sequencer, tare averaging
// and scaling, and compares each result field by field under random stalls.
// ----------------------------------------------------------------------------
module load_cell_adc_reader_with_tare_test;
  import lcar_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_RESERVED = 2'd3;
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_REPORTS    = 10;
  localparam logic [RAW_W-1:0] SIGN_FLIP = 24'h800000;

  typedef struct packed {
    logic                busy;
    logic [WEIGHT_W-1:0] weight;
    logic [RAW_W-1:0]    raw;
    logic                was_tare;
    logic                done;
    logic                clock_line;
  } tick_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COEF_W-1:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // model state
  phase_t             reader_phase;
  logic [4:0]         bit_count;
  logic [RAW_W-1:0]   shift_reg;
  logic               tare_mode;
  logic [SUM_W-1:0]   tare_sum;
  logic [7:0]         tare_count;
  logic [RAW_W-1:0]   tare_offset;
  logic [RAW_W-1:0]   last_raw;
  logic [COEF_W-1:0]  scale_coef;
  logic [TARE_N_W-1:0] tare_n;

  tick_result_t awaited_ticks[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int ticks_sent = 0;
  int results_checked = 0;
  int weighings = 0;
  int tares = 0;
  int mismatches = 0;
  int stall_cycles = 0;

  load_cell_adc_reader_with_tare u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void reset_reader();
    reader_phase = PH_IDLE;
    bit_count = '0;
    shift_reg = '0;
    tare_mode = 1'b0;
    tare_sum = '0;
    tare_count = '0;
    tare_offset = '0;
    last_raw = '0;
    scale_coef = COEF_RESET;
    tare_n = TARE_N_RESET;
  endfunction

  function automatic logic [7:0] tare_goal();
    return (tare_n == 0) ? 8'd1 : tare_n;
  endfunction

  // (raw - offset) * 256 / coef, toward zero, saturated
  function automatic logic [WEIGHT_W-1:0] scaled_weight(logic [RAW_W-1:0] raw);
    logic neg;
    logic [RAW_W-1:0] mag;
    logic [63:0] q;
    neg = raw < tare_offset;
    mag = neg ? tare_offset - raw : raw - tare_offset;
    if (mag == 0) return '0;
    if (scale_coef == 0) begin
      q = 64'(WEIGHT_MAX);
    end else begin
      q = (64'(mag) << 8) / 64'(scale_coef);
      if (q > 64'(WEIGHT_MAX)) q = 64'(WEIGHT_MAX);
    end
    return neg ? WEIGHT_W'(-q) : WEIGHT_W'(q);
  endfunction

  function automatic tick_result_t advance_reader(logic [ACTION_W-1:0] action,
                                                  logic data_line);
    tick_result_t r;
    logic [RAW_W-1:0] raw;
    logic [SUM_W-1:0] mean;
    r = '0;
    case (reader_phase)
      PH_IDLE: begin
        if (action == ACT_WEIGH || action == ACT_TARE) begin
          tare_mode = (action == ACT_TARE);
          tare_sum = '0;
          tare_count = '0;
          bit_count = '0;
          shift_reg = '0;
          reader_phase = PH_WAIT;
        end
      end
      PH_WAIT: begin
        if (!data_line) begin
          bit_count = '0;
          shift_reg = '0;
          reader_phase = PH_HIGH;
        end
      end
      PH_HIGH: begin
        r.clock_line = 1'b1;
        reader_phase = PH_LOW;
      end
      PH_LOW: begin
        shift_reg = {shift_reg[RAW_W-2:0], data_line};
        bit_count = bit_count + 5'd1;
        reader_phase = (bit_count == 5'(RAW_W)) ? PH_XHIGH : PH_HIGH;
      end
      PH_XHIGH: begin
        r.clock_line = 1'b1;
        reader_phase = PH_XLOW;
      end
      default: begin
        raw = shift_reg ^ SIGN_FLIP;
        last_raw = raw;
        if (tare_mode) begin
          tare_sum = tare_sum + SUM_W'(raw);
          tare_count = tare_count + 8'd1;
          if (tare_count >= tare_goal()) begin
            mean = tare_sum / SUM_W'(tare_goal());
            tare_offset = mean[RAW_W-1:0];
            r.done = 1'b1;
            r.was_tare = 1'b1;
            reader_phase = PH_IDLE;
          end else begin
            reader_phase = PH_WAIT;
          end
        end else begin
          r.weight = scaled_weight(raw);
          r.done = 1'b1;
          reader_phase = PH_IDLE;
        end
      end
    endcase
    r.raw = last_raw;
    r.busy = (reader_phase != PH_IDLE);
    return r;
  endfunction

  task automatic send_tick(logic [ACTION_W-1:0] action, logic data_line);
    logic [IN_TDATA_W-1:0] td;
    td = '0;
    td[IN_ACTION_LSB +: ACTION_W] = action;
    td[IN_DATA_BIT] = data_line;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata <= td;
    do @(posedge clk); while (!in_tready);
    awaited_ticks.push_back(advance_reader(action, data_line));
    ticks_sent++;
  endtask

  task automatic wait_results_done();
    in_tvalid <= 1'b0;
    while (awaited_ticks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] value);
    wait_results_done();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_SCALE_COEF) scale_coef = value;
    else tare_n = value[TARE_N_W-1:0];
  endtask

  function automatic logic [ACTION_W-1:0] any_action();
    return ACTION_W'($urandom_range(0, 3));
  endfunction

  // converter side of one conversion: ready wait, 24 bit pulses, extra pulse
  task automatic clock_in(logic [RAW_W-1:0] code, int unsigned nwait);
    repeat (nwait) send_tick(any_action(), 1'b1);
    send_tick(any_action(), 1'b0);
    for (int b = RAW_W - 1; b >= 0; b--) begin
      send_tick(any_action(), 1'($urandom_range(0, 1)));
      send_tick(any_action(), code[b]);
    end
    send_tick(any_action(), 1'($urandom_range(0, 1)));
    send_tick(any_action(), 1'($urandom_range(0, 1)));
  endtask

  function automatic int unsigned pick_wait();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
  endfunction

  // converter code whose offset-binary reading lands at raw
  function automatic logic [RAW_W-1:0] code_of(logic [RAW_W-1:0] raw);
    return raw ^ SIGN_FLIP;
  endfunction

  function automatic logic [RAW_W-1:0] pick_code();
    case ($urandom_range(0, 7))
      0: return 24'h000000;
      1: return 24'hFFFFFF;
      2: return SIGN_FLIP;
      3: return 24'h7FFFFF;
      4: return code_of(tare_offset + RAW_W'($urandom_range(0, 4000)) - 24'd2000);
      default: return RAW_W'($urandom());
    endcase
  endfunction

  task automatic weigh(logic [RAW_W-1:0] code);
    send_tick(ACT_WEIGH, 1'($urandom_range(0, 1)));
    clock_in(code, pick_wait());
    weighings++;
  endtask

  task automatic tare(logic [RAW_W-1:0] code, bit same_code);
    send_tick(ACT_TARE, 1'($urandom_range(0, 1)));
    repeat (tare_goal()) clock_in(same_code ? code : pick_code(), pick_wait());
    tares++;
  endtask

  task automatic idle_noise(int n);
    repeat (n) send_tick(($urandom_range(0, 1) != 0) ? ACT_RESERVED : ACT_TICK,
                         1'($urandom_range(0, 1)));
  endtask

  task automatic test_reset_defaults();
    idle_noise(4);
    weigh(SIGN_FLIP);
    weigh(24'h7FFFFF);
    weigh(24'hFFFFFF);
    send_tick(ACT_WEIGH, 1'b0);
    clock_in(24'h5A5A5A, 0);
    idle_noise(3);
  endtask

  task automatic test_tare_counts();
    write_register(REG_TARE_READING, 24'd0);
    tare(24'h812345, 1);
    weigh(24'h812345);
    weigh(24'h813345);
    write_register(REG_TARE_READING, 24'd1);
    tare(24'h400000, 1);
    weigh(24'h400001);
    write_register(REG_TARE_READING, 24'd3);
    tare(24'h0, 0);
    weigh(pick_code());
  endtask

  task automatic test_coefficient_extremes();
    logic [COEF_W-1:0] coefs[4] = '{24'd0, 24'd1, 24'd256, 24'hFFFFFF};
    foreach (coefs[i]) begin
      write_register(REG_SCALE_COEF, coefs[i]);
      weigh(code_of(tare_offset + 24'd1));
      weigh(code_of(tare_offset - 24'd1));
      if (coefs[i] == 24'd0) weigh(code_of(tare_offset));
      if (coefs[i] == 24'd1) weigh(code_of(tare_offset + 24'h400000));
    end
    write_register(REG_SCALE_COEF, COEF_RESET);
  endtask

  task automatic test_long_tare();
    write_register(REG_TARE_READING, 24'd6);
    tare(24'h7FFFFF, 1);
    weigh(pick_code());
    write_register(REG_TARE_READING, 24'(TARE_N_RESET));
  endtask

  function automatic logic [COEF_W-1:0] pick_coef();
    case ($urandom_range(0, 5))
      0: return COEF_W'($urandom_range(256, 4096));
      1: return COEF_W'($urandom_range(256, 24'hFFFFFF));
      2: return COEF_W'($urandom_range(1, 255));
      3: return 24'hFFFFFF;
      4: return 24'd256;
      default: return COEF_RESET;
    endcase
  endfunction

  task automatic test_random(int target);
    int start;
    start = ticks_sent;
    write_register(REG_SCALE_COEF, pick_coef());
    write_register(REG_TARE_READING, 24'($urandom_range(1, 4)));
    while (ticks_sent - start < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: weigh(pick_code());
        6, 7: tare(24'h0, 0);
        8: idle_noise($urandom_range(1, 6));
        default: begin
          if ($urandom_range(0, 1) != 0) write_register(REG_SCALE_COEF, pick_coef());
          else write_register(REG_TARE_READING, 24'($urandom_range(0, 4)));
        end
      endcase
    end
  endtask

  always @(posedge clk) out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

  always @(posedge clk) begin
    tick_result_t got;
    tick_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.clock_line = out_tdata[OUT_CLK_BIT];
      got.done       = out_tdata[OUT_DONE_BIT];
      got.was_tare   = out_tdata[OUT_TARE_BIT];
      got.raw        = out_tdata[OUT_RAW_LSB +: RAW_W];
      got.weight     = out_tdata[OUT_WEIGHT_LSB +: WEIGHT_W];
      got.busy       = out_tdata[OUT_BUSY_BIT];
      if (awaited_ticks.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result transaction: tdata=%014h", out_tdata);
      end else begin
        want = awaited_ticks.pop_front();
        results_checked++;
        if (got.clock_line !== want.clock_line || got.done !== want.done ||
            got.was_tare !== want.was_tare || got.raw !== want.raw ||
            got.weight !== want.weight || got.busy !== want.busy) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $write("mismatch at result %0d: clk %b/%b done %b/%b tare %b/%b ",
                   results_checked, want.clock_line, got.clock_line, want.done,
                   got.done, want.was_tare, got.was_tare);
            $display("raw %06h/%06h weight %07h/%07h busy %b/%b (expected/actual)",
                     want.raw, got.raw, want.weight, got.weight, want.busy, got.busy);
          end
        end
      end
    end
  end

  // no transaction on either side for too long means the block hung
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", stall_cycles);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    reset_reader();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 23;
    recv_idle_pct = 86;
    test_reset_defaults();
    test_tare_counts();
    test_coefficient_extremes();
    test_long_tare();
    test_random(60);

    send_idle_pct = 86;
    recv_idle_pct = 23;
    test_random(60);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(60);

    wait_results_done();
    $display("%0d ticks sent, %0d results checked, %0d mismatches", ticks_sent,
             results_checked, mismatches);
    $display("%0d weighings and %0d tares over coefficient and tare-count sweeps",
             weighings, tares);
    if (mismatches == 0 && awaited_ticks.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
